### rtl/accel_tilt_roll_pitch_core_assert.svh
// Assertion macros used by the tilt core.
`ifndef ACCEL_TILT_ROLL_PITCH_CORE_ASSERT_SVH
`define ACCEL_TILT_ROLL_PITCH_CORE_ASSERT_SVH

// Checks a property at every rising clock edge outside reset.
`define ATRP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition never holds at a rising clock edge outside reset.
`define ATRP_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### rtl/atrp_pkg.sv
package atrp_pkg;

    localparam int CORDIC_STAGES_DEF   = 16;
    localparam int ANGLE_FRAC_BITS_DEF = 13;
    localparam int ATAN_LEN            = 24;

    localparam int IN_W     = 16;
    localparam int AXW      = IN_W + 1;
    localparam int CW       = 32;
    localparam int AW       = 32;
    localparam int QW       = 34;
    localparam int GUARD_SH = 8;
    localparam int MAG_SH   = 4;

    localparam int SQ_SUM_W  = 32;
    localparam int SQ_IN_W   = SQ_SUM_W + 2 * MAG_SH;
    localparam int SQ_ROOT_W = SQ_IN_W / 2;
    localparam int SQ_REM_W  = SQ_ROOT_W + 2;

    localparam int ROLL_W  = 16;
    localparam int PITCH_W = 15;

    localparam logic signed [QW-1:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [QW-1:0] HALF_PI_Q30 = 34'sd1686629713;

    typedef struct packed {
        logic signed [AXW-1:0] roll_x;
        logic signed [AXW-1:0] roll_y;
        logic signed [AXW-1:0] neg_x;
        logic                  roll_zero;
        logic                  roll_neg;
        logic                  roll_ypos;
    } t_side;

    typedef struct packed {
        logic [SQ_IN_W-1:0]   src;
        logic [SQ_REM_W-1:0]  rem;
        logic [SQ_ROOT_W-1:0] root;
    } t_sqrt;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [AW-1:0] z;
    } t_vec;

    typedef struct packed {
        logic roll_zero;
        logic roll_neg;
        logic roll_ypos;
        logic pitch_zero;
        logic pitch_ovr;
        logic pitch_pos;
    } t_flags;

    function automatic logic signed [AW-1:0] atan_q30(input int unsigned idx);
        logic signed [AW-1:0] v;
        case (idx)
            0:       v = 32'sd843314856;
            1:       v = 32'sd497837829;
            2:       v = 32'sd263043836;
            3:       v = 32'sd133525158;
            4:       v = 32'sd67021686;
            5:       v = 32'sd33543515;
            6:       v = 32'sd16775850;
            7:       v = 32'sd8388437;
            8:       v = 32'sd4194282;
            9:       v = 32'sd2097149;
            10:      v = 32'sd1048575;
            11:      v = 32'sd524287;
            12:      v = 32'sd262143;
            13:      v = 32'sd131071;
            14:      v = 32'sd65535;
            15:      v = 32'sd32767;
            16:      v = 32'sd16383;
            17:      v = 32'sd8191;
            18:      v = 32'sd4095;
            19:      v = 32'sd2047;
            20:      v = 32'sd1023;
            21:      v = 32'sd511;
            22:      v = 32'sd255;
            23:      v = 32'sd127;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

### rtl/accel_tilt_roll_pitch_core.sv
// Roll and pitch from one raw accelerometer sample, fully pipelined.
// o_out_valid rises once the input transfer has passed, in order, through two square-and-sum stages,
// one stage per root bit of the magnitude, one per CORDIC stage, one rounding stage and the output
// register. Throughput: one sample per clock cycle while the pipeline is not stalled.
// The pipeline stalls only while its last stage and the output register both hold results and i_out_ready is low.
// Synchronous active-low reset clears all valid bits; no data is lost or repeated on a stall.
module accel_tilt_roll_pitch_core #(
    parameter int CORDIC_STAGES   = atrp_pkg::CORDIC_STAGES_DEF,
    parameter int ANGLE_FRAC_BITS = atrp_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    output logic                                    o_in_ready,
    input  logic signed [atrp_pkg::IN_W-1:0]        i_accel_x,
    input  logic signed [atrp_pkg::IN_W-1:0]        i_accel_y,
    input  logic signed [atrp_pkg::IN_W-1:0]        i_accel_z,
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output logic signed [atrp_pkg::ROLL_W-1:0]      o_roll_angle,
    output logic signed [atrp_pkg::PITCH_W-1:0]     o_pitch_angle
);
    import atrp_pkg::*;

    `include "accel_tilt_roll_pitch_core_assert.svh"

    localparam int                   RND_SH   = 30 - ANGLE_FRAC_BITS;
    localparam logic signed [QW-1:0] RND_HALF = QW'(64'sd1 <<< (29 - ANGLE_FRAC_BITS));
    localparam logic signed [QW-1:0] LIM_ROLL = (PI_Q30 + RND_HALF) >>> RND_SH;
    localparam logic signed [QW-1:0] LIM_PITCH = (HALF_PI_Q30 + RND_HALF) >>> RND_SH;
    localparam logic signed [QW-1:0] NEG_LIM_ROLL = -LIM_ROLL;
    localparam logic signed [QW-1:0] NEG_LIM_PITCH = -LIM_PITCH;

    logic en;

    // Front stages: squares, then their sum.
    logic                 r0_vld;
    t_side                r0_side;
    logic [SQ_SUM_W-1:0]  r0_sq_y;
    logic [SQ_SUM_W-1:0]  r0_sq_z;
    logic signed [2*IN_W-1:0] prod_y;
    logic signed [2*IN_W-1:0] prod_z;
    logic signed [AXW-1:0] ext_x;
    logic signed [AXW-1:0] ext_y;
    logic signed [AXW-1:0] ext_z;
    t_side                n0_side;

    logic                 r1_vld;
    t_side                r1_side;
    logic [SQ_SUM_W-1:0]  r1_sum;

    always_comb begin
        ext_x  = {i_accel_x[IN_W-1], i_accel_x};
        ext_y  = {i_accel_y[IN_W-1], i_accel_y};
        ext_z  = {i_accel_z[IN_W-1], i_accel_z};
        prod_y = (2*IN_W)'(i_accel_y) * (2*IN_W)'(i_accel_y);
        prod_z = (2*IN_W)'(i_accel_z) * (2*IN_W)'(i_accel_z);
        n0_side.neg_x     = -ext_x;
        n0_side.roll_neg  = i_accel_z[IN_W-1];
        n0_side.roll_ypos = !i_accel_y[IN_W-1];
        n0_side.roll_zero = (i_accel_y == '0);
        n0_side.roll_x    = i_accel_z[IN_W-1] ? -ext_z : ext_z;
        n0_side.roll_y    = i_accel_z[IN_W-1] ? -ext_y : ext_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
            r1_vld <= 1'b0;
        end else if (en) begin
            r0_vld <= i_in_valid;
            r1_vld <= r0_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_side <= n0_side;
            r0_sq_y <= prod_y;
            r0_sq_z <= prod_z;
            r1_side <= r0_side;
            r1_sum  <= r0_sq_y + r0_sq_z;
        end
    end

    // Magnitude of (y, z) with four fraction bits, one root bit per stage.
    logic  sq_vld  [0:SQ_ROOT_W];
    t_side sq_side [0:SQ_ROOT_W];
    t_sqrt sq_q    [0:SQ_ROOT_W];

    assign sq_vld[0]     = r1_vld;
    assign sq_side[0]    = r1_side;
    assign sq_q[0].src   = {r1_sum, {(2 * MAG_SH){1'b0}}};
    assign sq_q[0].rem   = '0;
    assign sq_q[0].root  = '0;

    for (genvar k = 0; k < SQ_ROOT_W; k++) begin : g_sqrt
        atrp_sqrt_stage u_sqrt (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_vld   (sq_vld[k]),
            .i_side  (sq_side[k]),
            .i_sq    (sq_q[k]),
            .o_vld   (sq_vld[k+1]),
            .o_side  (sq_side[k+1]),
            .o_sq    (sq_q[k+1])
        );
    end

    // Both vectoring CORDICs run side by side.
    logic   cv_vld   [0:CORDIC_STAGES];
    t_flags cv_flags [0:CORDIC_STAGES];
    t_vec   cv_roll  [0:CORDIC_STAGES];
    t_vec   cv_pitch [0:CORDIC_STAGES];
    t_side  fin_side;
    logic [SQ_ROOT_W-1:0] mag;

    always_comb begin
        fin_side = sq_side[SQ_ROOT_W];
        mag      = sq_q[SQ_ROOT_W].root;
        cv_flags[0].roll_zero  = fin_side.roll_zero;
        cv_flags[0].roll_neg   = fin_side.roll_neg;
        cv_flags[0].roll_ypos  = fin_side.roll_ypos;
        cv_flags[0].pitch_zero = (fin_side.neg_x == '0);
        cv_flags[0].pitch_ovr  = (mag == '0);
        cv_flags[0].pitch_pos  = !fin_side.neg_x[AXW-1] && (fin_side.neg_x != '0);
        cv_roll[0].x  = {{(CW - AXW - GUARD_SH){fin_side.roll_x[AXW-1]}},
                         fin_side.roll_x, {GUARD_SH{1'b0}}};
        cv_roll[0].y  = {{(CW - AXW - GUARD_SH){fin_side.roll_y[AXW-1]}},
                         fin_side.roll_y, {GUARD_SH{1'b0}}};
        cv_roll[0].z  = '0;
        cv_pitch[0].x = {{(CW - SQ_ROOT_W - GUARD_SH){1'b0}}, mag, {GUARD_SH{1'b0}}};
        cv_pitch[0].y = {{(CW - AXW - GUARD_SH - MAG_SH){fin_side.neg_x[AXW-1]}},
                         fin_side.neg_x, {(GUARD_SH + MAG_SH){1'b0}}};
        cv_pitch[0].z = '0;
    end

    assign cv_vld[0] = sq_vld[SQ_ROOT_W];

    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
        atrp_cordic_stage #(
            .SHIFT (k)
        ) u_cordic (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_vld   (cv_vld[k]),
            .i_flags (cv_flags[k]),
            .i_roll  (cv_roll[k]),
            .i_pitch (cv_pitch[k]),
            .o_vld   (cv_vld[k+1]),
            .o_flags (cv_flags[k+1]),
            .o_roll  (cv_roll[k+1]),
            .o_pitch (cv_pitch[k+1])
        );
    end

    // Rounding stage: quadrant offset, special cases and the rounding half.
    t_flags              lf;
    logic signed [QW-1:0] z_roll;
    logic signed [QW-1:0] z_pitch;
    logic signed [QW-1:0] off_roll;
    logic signed [QW-1:0] base_pitch;
    logic                 r_rnd_vld;
    logic signed [QW-1:0] r_rnd_roll;
    logic signed [QW-1:0] r_rnd_pitch;

    always_comb begin
        lf      = cv_flags[CORDIC_STAGES];
        z_roll  = QW'(cv_roll[CORDIC_STAGES].z);
        z_pitch = QW'(cv_pitch[CORDIC_STAGES].z);
        if (lf.roll_zero) begin
            z_roll = '0;
        end
        if (!lf.roll_neg) begin
            off_roll = RND_HALF;
        end else if (lf.roll_ypos) begin
            off_roll = PI_Q30 + RND_HALF;
        end else begin
            off_roll = RND_HALF - PI_Q30;
        end
        if (lf.pitch_zero) begin
            base_pitch = '0;
        end else if (!lf.pitch_ovr) begin
            base_pitch = z_pitch;
        end else if (lf.pitch_pos) begin
            base_pitch = HALF_PI_Q30;
        end else begin
            base_pitch = -HALF_PI_Q30;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rnd_vld <= 1'b0;
        end else if (en) begin
            r_rnd_vld <= cv_vld[CORDIC_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rnd_roll  <= z_roll + off_roll;
            r_rnd_pitch <= base_pitch + RND_HALF;
        end
    end

    // Output register with clamping.
    logic                        r_out_vld;
    logic signed [ROLL_W-1:0]    r_roll;
    logic signed [PITCH_W-1:0]   r_pitch;
    logic signed [QW-1:0]        sh_roll;
    logic signed [QW-1:0]        sh_pitch;
    logic signed [QW-1:0]        n_roll;
    logic signed [QW-1:0]        n_pitch;
    logic                        load;

    always_comb begin
        sh_roll  = r_rnd_roll >>> RND_SH;
        sh_pitch = r_rnd_pitch >>> RND_SH;
        if (sh_roll > LIM_ROLL) begin
            n_roll = LIM_ROLL;
        end else if (sh_roll < NEG_LIM_ROLL) begin
            n_roll = NEG_LIM_ROLL;
        end else begin
            n_roll = sh_roll;
        end
        if (sh_pitch > LIM_PITCH) begin
            n_pitch = LIM_PITCH;
        end else if (sh_pitch < NEG_LIM_PITCH) begin
            n_pitch = NEG_LIM_PITCH;
        end else begin
            n_pitch = sh_pitch;
        end
    end

    assign en   = !r_rnd_vld || !r_out_vld || i_out_ready;
    assign load = r_rnd_vld && en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (load) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_roll  <= n_roll[ROLL_W-1:0];
            r_pitch <= n_pitch[PITCH_W-1:0];
        end
    end

    assign o_in_ready    = en;
    assign o_out_valid   = r_out_vld;
    assign o_roll_angle  = r_roll;
    assign o_pitch_angle = r_pitch;

    // The input is held off only when the last stage and the output register are both full and i_out_ready is low.
    `ATRP_ASSERT(a_stall_cause, i_clk, i_rst_n, !o_in_ready |-> (r_out_vld && r_rnd_vld && !i_out_ready), "input held off without a full output")
    // A stalled result in the last stage is neither dropped nor altered.
    `ATRP_ASSERT(a_stall_hold, i_clk, i_rst_n, (r_rnd_vld && !en) |=> (r_rnd_vld && $stable(r_rnd_roll) && $stable(r_rnd_pitch)), "stalled result lost")
    // The square root remainder never exceeds twice the root.
    `ATRP_ASSERT_NEVER(a_sqrt_rem, i_clk, i_rst_n, sq_vld[SQ_ROOT_W] && (sq_q[SQ_ROOT_W].rem > {1'b0, sq_q[SQ_ROOT_W].root, 1'b0}), "square root remainder out of range")
    // A new result appears only from a valid last stage.
    `ATRP_ASSERT(a_out_source, i_clk, i_rst_n, $rose(r_out_vld) |-> $past(r_rnd_vld), "result without a source")

endmodule

### rtl/atrp_sqrt_stage.sv
module atrp_sqrt_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_vld,
    input  atrp_pkg::t_side i_side,
    input  atrp_pkg::t_sqrt i_sq,
    output logic            o_vld,
    output atrp_pkg::t_side o_side,
    output atrp_pkg::t_sqrt o_sq
);
    import atrp_pkg::*;

    logic                 r_vld;
    t_side                r_side;
    t_sqrt                r_sq;
    t_sqrt                n_sq;
    logic [SQ_REM_W-1:0]  rem_sh;
    logic [SQ_REM_W-1:0]  trial;
    logic                 take;

    // One result bit per stage: bring down two source bits, try root*4+1.
    always_comb begin
        rem_sh     = {i_sq.rem[SQ_REM_W-3:0], i_sq.src[SQ_IN_W-1 -: 2]};
        trial      = {i_sq.root, 2'b01};
        take       = (rem_sh >= trial);
        n_sq.src   = {i_sq.src[SQ_IN_W-3:0], 2'b00};
        n_sq.rem   = take ? (rem_sh - trial) : rem_sh;
        n_sq.root  = {i_sq.root[SQ_ROOT_W-2:0], take};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= i_side;
            r_sq   <= n_sq;
        end
    end

    assign o_vld  = r_vld;
    assign o_side = r_side;
    assign o_sq   = r_sq;

endmodule

### rtl/atrp_cordic_stage.sv
module atrp_cordic_stage #(
    parameter int SHIFT = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  atrp_pkg::t_flags i_flags,
    input  atrp_pkg::t_vec   i_roll,
    input  atrp_pkg::t_vec   i_pitch,
    output logic             o_vld,
    output atrp_pkg::t_flags o_flags,
    output atrp_pkg::t_vec   o_roll,
    output atrp_pkg::t_vec   o_pitch
);
    import atrp_pkg::*;

    localparam logic signed [AW-1:0] ATAN = atan_q30(SHIFT);

    logic   r_vld;
    t_flags r_flags;
    t_vec   r_roll;
    t_vec   r_pitch;
    t_vec   n_roll;
    t_vec   n_pitch;

    function automatic t_vec rotate(input t_vec v);
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [AW-1:0] z;
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        t_vec                 r;
        x  = v.x;
        y  = v.y;
        z  = v.z;
        dx = y >>> SHIFT;
        dy = x >>> SHIFT;
        if (!y[CW-1]) begin
            r.x = x + dx;
            r.y = y - dy;
            r.z = z + ATAN;
        end else begin
            r.x = x - dx;
            r.y = y + dy;
            r.z = z - ATAN;
        end
        return r;
    endfunction

    always_comb begin
        n_roll  = rotate(i_roll);
        n_pitch = rotate(i_pitch);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_flags <= i_flags;
            r_roll  <= n_roll;
            r_pitch <= n_pitch;
        end
    end

    assign o_vld   = r_vld;
    assign o_flags = r_flags;
    assign o_roll  = r_roll;
    assign o_pitch = r_pitch;

endmodule
